/* src/rrc_pkg.sv */
// ----------------------------------------------------------------------------
// rrc_pkg
// Shared types and constants for the rounded rectangle coverage block.
// ----------------------------------------------------------------------------
package rrc_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int DIST_FRAC_DEF  = 8;

  localparam int WID_W  = 11;  // rect width / height
  localparam int CR_W   = 10;  // corner radius
  localparam int SW_W   = 8;   // stroke width
  localparam int MODE_W = 2;
  localparam int RAD_W  = 11;  // radius + stroke, up to 1278
  localparam int MAG_W  = 12;  // |2*dx+1| inside any corner square, up to 2555
  localparam int COV_W  = 4;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  localparam logic [COV_W-1:0] COV_NONE = 4'd0;
  localparam logic [COV_W-1:0] COV_FULL = 4'd15;

  typedef enum logic [MODE_W-1:0] {
    MODE_FILL  = 2'd0,
    MODE_INNER = 2'd1,
    MODE_OUTER = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    REG_LEFT   = 3'd0,
    REG_TOP    = 3'd1,
    REG_WIDTH  = 3'd2,
    REG_HEIGHT = 3'd3,
    REG_RADIUS = 3'd4,
    REG_STROKE = 3'd5,
    REG_MODE   = 3'd6
  } reg_idx_e;

  localparam logic [ADDR_W-1:0] ADDR_DRAW_MODE = 5'd24;

  // Per-pixel decision carried alongside the distance operands.
  typedef struct packed {
    logic             corner;  // coverage comes from the distance
    logic [COV_W-1:0] cov;     // coverage when not a corner pixel
    logic [RAD_W-1:0] rad_hi;
    logic [RAD_W-1:0] rad_lo;
    logic             use_lo;  // subtract the inner term
  } side_t;

  typedef struct packed {
    side_t            side;
    logic [MAG_W-1:0] dx_mag;
    logic [MAG_W-1:0] dy_mag;
  } item_t;

endpackage

/* src/rrc_front.sv */
// ----------------------------------------------------------------------------
// rrc_front
// Offsets the pixel against the rectangle origin and classifies it: fixed
// coverage, or a corner pixel with its radii and distance operands.
// ----------------------------------------------------------------------------
module rrc_front import rrc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic signed [COORD_BITS-1:0] pixel_x_i,
  input  logic signed [COORD_BITS-1:0] pixel_y_i,
  input  logic                         pixel_valid_i,
  output logic                         pixel_ready_o,
  input  logic signed [COORD_BITS-1:0] rect_left_i,
  input  logic signed [COORD_BITS-1:0] rect_top_i,
  input  logic [WID_W-1:0]             rect_width_i,
  input  logic [WID_W-1:0]             rect_height_i,
  input  logic [CR_W-1:0]              corner_radius_i,
  input  logic [SW_W-1:0]              stroke_width_i,
  input  logic [MODE_W-1:0]            draw_mode_i,
  output item_t                        item_o,
  output logic                         item_valid_o,
  input  logic                         item_ready_i
);

  localparam int UW = COORD_BITS + 1;
  localparam int CW = ((UW > 13) ? UW : 13) + 1;

  logic                 en;
  logic                 a_valid_q, b_valid_q;
  logic signed [UW-1:0] u_q, v_q, u_d, v_d;
  item_t                item_q, item_d;

  logic signed [CW-1:0] u, v, w, h, cr, sw, r, wr, hr, cx, cy, dx, dy, dx2, dy2;
  logic signed [CW-1:0] rhi, rlo;
  logic                 in_rect, ccol, crow;

  assign en            = !b_valid_q || item_ready_i;
  assign pixel_ready_o = en;

  assign u_d = $signed({pixel_x_i[COORD_BITS-1], pixel_x_i})
             - $signed({rect_left_i[COORD_BITS-1], rect_left_i});
  assign v_d = $signed({pixel_y_i[COORD_BITS-1], pixel_y_i})
             - $signed({rect_top_i[COORD_BITS-1], rect_top_i});

  always_comb begin
    u  = CW'(u_q);
    v  = CW'(v_q);
    w  = CW'($signed({1'b0, rect_width_i}));
    h  = CW'($signed({1'b0, rect_height_i}));
    cr = CW'($signed({1'b0, corner_radius_i}));
    sw = CW'($signed({1'b0, stroke_width_i}));
    r  = cr;
    if (r > (w >>> 1)) r = w >>> 1;
    if (r > (h >>> 1)) r = h >>> 1;
    wr = w - r;
    hr = h - r;
    in_rect = (u >= 0) && (u < w) && (v >= 0) && (v < h);

    // corner centre and odd doubled offsets to the pixel centre
    cx  = (u < r) ? r : wr;
    cy  = (v < r) ? r : hr;
    dx  = u - cx;
    dy  = v - cy;
    dx2 = dx[CW-1] ? (-(dx <<< 1) - CW'(1)) : ((dx <<< 1) + CW'(1));
    dy2 = dy[CW-1] ? (-(dy <<< 1) - CW'(1)) : ((dy <<< 1) + CW'(1));

    rhi  = r;
    rlo  = r - sw;
    ccol = 1'b0;
    crow = 1'b0;
    item_d.side.corner = 1'b0;
    item_d.side.cov    = COV_NONE;
    item_d.side.use_lo = 1'b0;

    if (w != 0 && h != 0) begin
      case (mode_e'(draw_mode_i))
        MODE_FILL: begin
          ccol = (u < r) || (u >= wr);
          crow = (v < r) || (v >= hr);
          if (in_rect) begin
            if (r != 0 && ccol && crow) item_d.side.corner = 1'b1;
            else                        item_d.side.cov    = COV_FULL;
          end
        end
        MODE_INNER: begin
          if (sw != 0) begin
            if (r == 0) begin
              if (in_rect && ((u < sw) || (u >= w - sw) || (v < sw) || (v >= h - sw)))
                item_d.side.cov = COV_FULL;
            end else begin
              ccol = ((u >= 0) && (u < r)) || ((u >= wr) && (u < w));
              crow = ((v >= 0) && (v < r)) || ((v >= hr) && (v < h));
              if (ccol && crow) begin
                item_d.side.corner = 1'b1;
                item_d.side.use_lo = (r > sw);
              end else if ((u >= r) && (u < wr) &&
                           (((v >= 0) && (v < sw)) || ((v >= h - sw) && (v < h)))) begin
                item_d.side.cov = COV_FULL;
              end else if ((v >= r) && (v < hr) &&
                           (((u >= 0) && (u < sw)) || ((u >= w - sw) && (u < w)))) begin
                item_d.side.cov = COV_FULL;
              end
            end
          end
        end
        MODE_OUTER: begin
          if (sw != 0) begin
            if (r == 0) begin
              if (!in_rect && (u >= -sw) && (u < w + sw) && (v >= -sw) && (v < h + sw))
                item_d.side.cov = COV_FULL;
            end else begin
              ccol = ((u >= -sw) && (u < r)) || ((u >= wr) && (u < w + sw));
              crow = ((v >= -sw) && (v < r)) || ((v >= hr) && (v < h + sw));
              rhi  = r + sw;
              rlo  = r;
              if (ccol && crow) begin
                item_d.side.corner = 1'b1;
                item_d.side.use_lo = 1'b1;
              end else if ((u >= r) && (u < wr) &&
                           (((v >= -sw) && (v < 0)) || ((v >= h) && (v < h + sw)))) begin
                item_d.side.cov = COV_FULL;
              end else if ((v >= r) && (v < hr) &&
                           (((u >= -sw) && (u < 0)) || ((u >= w) && (u < w + sw)))) begin
                item_d.side.cov = COV_FULL;
              end
            end
          end
        end
        default: begin
          item_d.side.cov = COV_NONE;
        end
      endcase
    end

    item_d.side.rad_hi = RAD_W'(rhi);
    item_d.side.rad_lo = RAD_W'(rlo);
    item_d.dx_mag      = MAG_W'(dx2);
    item_d.dy_mag      = MAG_W'(dy2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else if (en) begin
      a_valid_q <= pixel_valid_i;
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      u_q    <= u_d;
      v_q    <= v_d;
      item_q <= item_d;
    end
  end

  assign item_o       = item_q;
  assign item_valid_o = b_valid_q;

endmodule

/* src/rrc_fifo.sv */
// ----------------------------------------------------------------------------
// rrc_fifo
// Short queue of classified words between the front and the back.
// ----------------------------------------------------------------------------
module rrc_fifo import rrc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  item_t push_data_i,
  input  logic  push_valid_i,
  output logic  push_ready_o,
  output item_t pop_data_o,
  output logic  pop_valid_o,
  input  logic  pop_ready_i
);

  item_t                mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [FIFO_AW:0]     count_q;
  logic                 push, pop;

  assign push_ready_o = (count_q != (FIFO_AW+1)'(FIFO_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
      if (pop)  rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
      if (push && !pop)      count_q <= count_q + (FIFO_AW+1)'(1);
      else if (pop && !push) count_q <= count_q - (FIFO_AW+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

/* src/rrc_back.sv */
// ----------------------------------------------------------------------------
// rrc_back
// Corner distance by a pipelined bit-per-stage square root, the two clamped
// coverage terms and the final rounding to 4 bits.
// ----------------------------------------------------------------------------
module rrc_back import rrc_pkg::*; #(
  parameter int DIST_FRAC_BITS = DIST_FRAC_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  item_t            item_i,
  input  logic             item_valid_i,
  output logic             item_ready_o,
  output logic [COV_W-1:0] coverage_o,
  output logic             coverage_valid_o,
  input  logic             coverage_ready_i
);

  localparam int F      = DIST_FRAC_BITS;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int S_W    = 2 * MAG_W + 2 * F - 1;
  localparam int TR     = S_W + 1;
  localparam int ROOT_W = MAG_W + F;
  localparam int NS     = ROOT_W;
  localparam int TW     = ROOT_W + 2;
  localparam int ONE    = 1 << F;
  localparam int HALF   = 1 << (F - 1);

  logic en;

  // squares
  logic [SQ_W-1:0] sqx_q, sqy_q;
  side_t           sq_side_q;
  logic            sq_valid_q;

  // sum, then one root bit per stage
  logic [TR-1:0]     rem_q  [NS+1];
  logic [ROOT_W-1:0] root_q [NS+1];
  side_t             side_q [NS+1];
  logic              vld_q  [NS+1];

  // clamped terms
  logic [F:0]        th_q, tl_q, th_d, tl_d;
  side_t             t_side_q;
  logic              t_valid_q;
  logic [TW-1:0]     c_hi, c_lo;

  logic [F+1:0]      ad;
  logic [F+5:0]      scaled;
  logic [COV_W-1:0]  cov_d, cov_q;
  logic              out_valid_q;

  assign en               = !out_valid_q || coverage_ready_i;
  assign item_ready_o     = en;
  assign coverage_o       = cov_q;
  assign coverage_valid_o = out_valid_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqx_q     <= item_i.dx_mag * item_i.dx_mag;
      sqy_q     <= item_i.dy_mag * item_i.dy_mag;
      sq_side_q <= item_i.side;
      rem_q[0]  <= TR'({1'b0, sqx_q} + {1'b0, sqy_q}) << (2 * F - 2);
      root_q[0] <= '0;
      side_q[0] <= sq_side_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_valid_q <= 1'b0;
      vld_q[0]   <= 1'b0;
    end else if (en) begin
      sq_valid_q <= item_valid_i;
      vld_q[0]   <= sq_valid_q;
    end
  end

  for (genvar j = 1; j <= NS; j++) begin : g_root
    localparam int K = NS - j;
    logic [TR-1:0] trial;
    logic          take;

    assign trial = (TR'(root_q[j-1]) << (K + 1)) | (TR'(1) << (2 * K));
    assign take  = (rem_q[j-1] >= trial);

    always_ff @(posedge clk_i) begin
      if (en) begin
        rem_q[j]  <= take ? (rem_q[j-1] - trial) : rem_q[j-1];
        root_q[j] <= take ? (root_q[j-1] | (ROOT_W'(1) << K)) : root_q[j-1];
        side_q[j] <= side_q[j-1];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni)  vld_q[j] <= 1'b0;
      else if (en) vld_q[j] <= vld_q[j-1];
    end
  end

  // term(R) = clamp(HALF + R*ONE - d, 0, ONE); MSB of c is its sign
  always_comb begin
    c_hi = (TW'(side_q[NS].rad_hi) << F) + TW'(HALF) - TW'(root_q[NS]);
    c_lo = (TW'(side_q[NS].rad_lo) << F) + TW'(HALF) - TW'(root_q[NS]);
    if (c_hi[TW-1] || c_hi == '0)  th_d = '0;
    else if (c_hi >= TW'(ONE))    th_d = (F+1)'(ONE);
    else                          th_d = (F+1)'(c_hi);
    if (!side_q[NS].use_lo || c_lo[TW-1] || c_lo == '0) tl_d = '0;
    else if (c_lo >= TW'(ONE))                          tl_d = (F+1)'(ONE);
    else                                                tl_d = (F+1)'(c_lo);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      th_q     <= th_d;
      tl_q     <= tl_d;
      t_side_q <= side_q[NS];
      cov_q    <= cov_d;
    end
  end

  // a*15 rounded half up, saturated
  always_comb begin
    ad     = {1'b0, th_q} - {1'b0, tl_q};
    scaled = ((F+6)'(ad) << 4) - (F+6)'(ad) + (F+6)'(HALF);
    if (!t_side_q.corner)             cov_d = t_side_q.cov;
    else if (ad[F+1] || ad == '0)     cov_d = COV_NONE;
    else if (ad >= (F+2)'(ONE))       cov_d = COV_FULL;
    else                              cov_d = scaled[F+COV_W-1:F];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      t_valid_q   <= vld_q[NS];
      out_valid_q <= t_valid_q;
    end
  end

endmodule

/* src/rounded_rect_aa_coverage.sv */
// ----------------------------------------------------------------------------
// rounded_rect_aa_coverage
// Antialiased rounded rectangle coverage, one 4-bit value per pixel word.
// ----------------------------------------------------------------------------
// Pixel path: the accept edge loads the offsets; then classify, queue write,
//   squares, sum, 12 + DIST_FRAC_BITS root stages, terms, output register.
// Throughput: one pixel per cycle unless the output stalls; the root is one
//   pipelined stage per bit.
// Reset: all pipeline and queue valids clear; registers take their reset
//   values (stroke_width 1, all others 0).
module rounded_rect_aa_coverage import rrc_pkg::*; #(
  parameter int COORD_BITS     = COORD_BITS_DEF,
  parameter int DIST_FRAC_BITS = DIST_FRAC_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic signed [COORD_BITS-1:0] pixel_x_i,
  input  logic signed [COORD_BITS-1:0] pixel_y_i,
  input  logic                         pixel_valid_i,
  output logic                         pixel_ready_o,
  output logic [COV_W-1:0]             coverage_o,
  output logic                         coverage_valid_o,
  input  logic                         coverage_ready_i,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ADDR_W-1:0]            paddr,
  input  logic [DATA_W-1:0]            pwdata,
  output logic [DATA_W-1:0]            prdata,
  output logic                         pready
);

  logic [COORD_BITS-1:0] rect_left_q, rect_top_q;
  logic [WID_W-1:0]      rect_width_q, rect_height_q;
  logic [CR_W-1:0]       corner_radius_q;
  logic [SW_W-1:0]       stroke_width_q;
  logic [MODE_W-1:0]     draw_mode_q;
  reg_idx_e              idx;
  logic                  wr_en;

  item_t fr_item, bk_item;
  logic  fr_valid, fr_ready, bk_valid, bk_ready;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rect_left_q     <= '0;
      rect_top_q      <= '0;
      rect_width_q    <= '0;
      rect_height_q   <= '0;
      corner_radius_q <= '0;
      stroke_width_q  <= SW_W'(1);
      draw_mode_q     <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_LEFT:   rect_left_q     <= pwdata[COORD_BITS-1:0];
        REG_TOP:    rect_top_q      <= pwdata[COORD_BITS-1:0];
        REG_WIDTH:  rect_width_q    <= pwdata[WID_W-1:0];
        REG_HEIGHT: rect_height_q   <= pwdata[WID_W-1:0];
        REG_RADIUS: corner_radius_q <= pwdata[CR_W-1:0];
        REG_STROKE: stroke_width_q  <= pwdata[SW_W-1:0];
        REG_MODE:   draw_mode_q     <= pwdata[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_LEFT:   prdata = DATA_W'(rect_left_q);
      REG_TOP:    prdata = DATA_W'(rect_top_q);
      REG_WIDTH:  prdata = DATA_W'(rect_width_q);
      REG_HEIGHT: prdata = DATA_W'(rect_height_q);
      REG_RADIUS: prdata = DATA_W'(corner_radius_q);
      REG_STROKE: prdata = DATA_W'(stroke_width_q);
      REG_MODE:   prdata = DATA_W'(draw_mode_q);
      default:    prdata = '0;
    endcase
  end

  rrc_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .pixel_x_i       (pixel_x_i),
    .pixel_y_i       (pixel_y_i),
    .pixel_valid_i   (pixel_valid_i),
    .pixel_ready_o   (pixel_ready_o),
    .rect_left_i     (rect_left_q),
    .rect_top_i      (rect_top_q),
    .rect_width_i    (rect_width_q),
    .rect_height_i   (rect_height_q),
    .corner_radius_i (corner_radius_q),
    .stroke_width_i  (stroke_width_q),
    .draw_mode_i     (draw_mode_q),
    .item_o          (fr_item),
    .item_valid_o    (fr_valid),
    .item_ready_i    (fr_ready)
  );

  rrc_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (fr_item),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .pop_data_o   (bk_item),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready)
  );

  rrc_back #(
    .DIST_FRAC_BITS (DIST_FRAC_BITS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .item_i           (bk_item),
    .item_valid_i     (bk_valid),
    .item_ready_o     (bk_ready),
    .coverage_o       (coverage_o),
    .coverage_valid_o (coverage_valid_o),
    .coverage_ready_i (coverage_ready_i)
  );

endmodule

/* src/rrc_checker.sv */
// ----------------------------------------------------------------------------
// rrc_checker
// Port-level checks for the rounded rectangle coverage block.
// ----------------------------------------------------------------------------
module rrc_checker import rrc_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              coverage_valid_o,
  input logic              coverage_ready_i,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [ADDR_W-1:0] paddr,
  input logic [DATA_W-1:0] pwdata,
  input logic [DATA_W-1:0] prdata,
  input logic              pready
);

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    coverage_valid_o && !coverage_ready_i |=> coverage_valid_o)
    else $error("coverage word dropped while stalled");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !coverage_valid_o)
    else $error("coverage valid during reset");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

  a_mode_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && paddr == ADDR_DRAW_MODE) ##1
    (psel && !pwrite && paddr == ADDR_DRAW_MODE)
    |-> prdata[MODE_W-1:0] == $past(pwdata[MODE_W-1:0]))
    else $error("draw_mode readback mismatch");

endmodule

bind rounded_rect_aa_coverage rrc_checker u_rrc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .coverage_valid_o (coverage_valid_o),
  .coverage_ready_i (coverage_ready_i),
  .psel             (psel),
  .penable          (penable),
  .pwrite           (pwrite),
  .paddr            (paddr),
  .pwdata           (pwdata),
  .prdata           (prdata),
  .pready           (pready)
);

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Checks rounded_rect_aa_coverage against a behavioral coverage predictor:
// directed rows first, then random phases over many rectangle settings,
// with random idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
module testbench;
  import rrc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB       = COORD_BITS_DEF;
  localparam int FB       = DIST_FRAC_DEF;
  localparam int LATENCY  = DIST_FRAC_DEF + 18;
  localparam int WDOG_MAX = 20000;
  localparam int N_RAND   = 1500;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic signed [CB-1:0] pixel_x_i = '0;
  logic signed [CB-1:0] pixel_y_i = '0;
  logic                 pixel_valid_i = 1'b0;
  logic                 pixel_ready_o;
  logic [COV_W-1:0]     coverage_o;
  logic                 coverage_valid_o;
  logic                 coverage_ready_i = 1'b0;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [ADDR_W-1:0]    paddr = '0;
  logic [DATA_W-1:0]    pwdata = '0;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;

  rounded_rect_aa_coverage dut (.*);

  always #5 clk_i = ~clk_i;

  // shadow copy of the registers
  logic signed [CB-1:0] s_left = '0, s_top = '0;
  logic [WID_W-1:0]     s_w = '0, s_h = '0;
  logic [CR_W-1:0]      s_rad = '0;
  logic [SW_W-1:0]      s_sw = 8'd1;
  logic [MODE_W-1:0]    s_mode = MODE_FILL;

  logic [COV_W-1:0] cov_q[$];
  int errors = 0;
  int mism = 0;
  int idle_cycles = 0;
  bit quiet = 0;     // no idling stretch
  bit hold_rx = 0;   // long receiver hold-off

  function automatic longint root64(longint unsigned v);
    longint unsigned res = 0, b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint center_dist(longint u, longint v, longint cx, longint cy);
    longint dx = 2 * (u - cx) + 1;
    longint dy = 2 * (v - cy) + 1;
    longint unsigned s = longint'(dx * dx + dy * dy);
    return root64(s << (2 * FB - 2));
  endfunction

  function automatic longint edge_term(longint rr, longint d);
    longint c = (1 << (FB - 1)) + rr * (1 << FB) - d;
    if (c <= 0) return 0;
    if (c >= (1 << FB)) return 1 << FB;
    return c;
  endfunction

  function automatic logic [COV_W-1:0] fx_to_cov(longint a);
    if (a <= 0) return COV_NONE;
    if (a >= (1 << FB)) return COV_FULL;
    return COV_W'((a * 15 + (1 << (FB - 1))) >> FB);
  endfunction

  function automatic bit rng(longint a, longint lo, longint hi);
    return a >= lo && a < hi;
  endfunction

  function automatic logic [COV_W-1:0] predict_cov(logic signed [CB-1:0] px,
                                                   logic signed [CB-1:0] py);
    longint u = longint'(px) - longint'(s_left);
    longint v = longint'(py) - longint'(s_top);
    longint w = s_w, h = s_h, r = s_rad, sw = s_sw;
    bit ins = u >= 0 && u < w && v >= 0 && v < h;
    bit ccol, crow;
    longint cx, cy, d, e;
    if (w == 0 || h == 0 || s_mode == 2'd3) return COV_NONE;
    if (r > w / 2) r = w / 2;
    if (r > h / 2) r = h / 2;
    cx = (u < r) ? r : w - r;
    cy = (v < r) ? r : h - r;
    if (s_mode == MODE_FILL) begin
      if (!ins) return COV_NONE;
      if (r == 0) return COV_FULL;
      if (!((u < r || u >= w - r) && (v < r || v >= h - r))) return COV_FULL;
      return fx_to_cov(edge_term(r, center_dist(u, v, cx, cy)));
    end
    if (sw == 0) return COV_NONE;
    if (r == 0) begin
      if (s_mode == MODE_INNER) begin
        if (!ins) return COV_NONE;
        d = u;
        if (w - 1 - u < d) d = w - 1 - u;
        if (v < d) d = v;
        if (h - 1 - v < d) d = h - 1 - v;
        return d < sw ? COV_FULL : COV_NONE;
      end
      if (ins) return COV_NONE;
      d = -u;
      e = u - (w - 1); if (e > d) d = e;
      e = -v; if (e > d) d = e;
      e = v - (h - 1); if (e > d) d = e;
      return d <= sw ? COV_FULL : COV_NONE;
    end
    if (s_mode == MODE_INNER) begin
      ccol = rng(u, 0, r) || rng(u, w - r, w);
      crow = rng(v, 0, r) || rng(v, h - r, h);
      if (ccol && crow) begin
        d = center_dist(u, v, cx, cy);
        if (r > sw) return fx_to_cov(edge_term(r, d) - edge_term(r - sw, d));
        return fx_to_cov(edge_term(r, d));
      end
      if (rng(u, r, w - r) && (rng(v, 0, sw) || rng(v, h - sw, h))) return COV_FULL;
      if (rng(v, r, h - r) && (rng(u, 0, sw) || rng(u, w - sw, w))) return COV_FULL;
      return COV_NONE;
    end
    ccol = rng(u, -sw, r) || rng(u, w - r, w + sw);
    crow = rng(v, -sw, r) || rng(v, h - r, h + sw);
    if (ccol && crow) begin
      d = center_dist(u, v, cx, cy);
      return fx_to_cov(edge_term(r + sw, d) - edge_term(r, d));
    end
    if (rng(u, r, w - r) && (rng(v, -sw, 0) || rng(v, h, h + sw))) return COV_FULL;
    if (rng(v, r, h - r) && (rng(u, -sw, 0) || rng(u, w, w + sw))) return COV_FULL;
    return COV_NONE;
  endfunction

  task automatic reg_write(reg_idx_e idx, logic [DATA_W-1:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_W'(4 * idx); pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    while (!pready) @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_LEFT:   s_left = val[CB-1:0];
      REG_TOP:    s_top  = val[CB-1:0];
      REG_WIDTH:  s_w    = val[WID_W-1:0];
      REG_HEIGHT: s_h    = val[WID_W-1:0];
      REG_RADIUS: s_rad  = val[CR_W-1:0];
      REG_STROKE: s_sw   = val[SW_W-1:0];
      REG_MODE:   s_mode = val[MODE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_shape(int l, int t, int w, int h, int r, int sw, int md);
    reg_write(REG_LEFT, DATA_W'(l));
    reg_write(REG_TOP, DATA_W'(t));
    reg_write(REG_WIDTH, DATA_W'(w));
    reg_write(REG_HEIGHT, DATA_W'(h));
    reg_write(REG_RADIUS, DATA_W'(r));
    reg_write(REG_STROKE, DATA_W'(sw));
    reg_write(REG_MODE, DATA_W'(md));
  endtask

  task automatic drain();
    pixel_valid_i <= 1'b0;
    while (cov_q.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 4) @(negedge clk_i);
  endtask

  // send one pixel word; the predictor gives the expected value, and exp_cov >= 0 is checked against it
  task automatic send_pixel(int x, int y, int exp_cov);
    logic [COV_W-1:0] p;
    while (!quiet && $urandom_range(99) < 28) begin
      pixel_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    pixel_x_i <= CB'(x);
    pixel_y_i <= CB'(y);
    pixel_valid_i <= 1'b1;
    p = predict_cov(CB'(x), CB'(y));
    if (exp_cov >= 0 && p != COV_W'(exp_cov)) begin
      $display("table row disagrees with predictor at (%0d,%0d)", x, y);
      errors++;
    end
    @(posedge clk_i);
    while (!pixel_ready_o) @(posedge clk_i);
    cov_q.push_back(p);
    @(negedge clk_i);
  endtask

  typedef struct {
    int x, y, c;
  } row_t;

  // receiver
  always @(negedge clk_i) begin
    if (hold_rx) coverage_ready_i <= 1'b0;
    else coverage_ready_i <= quiet || ($urandom_range(99) >= 28);
  end

  // check
  always @(posedge clk_i) begin
    if (rst_ni && coverage_valid_o && coverage_ready_i) begin
      if (cov_q.size() == 0) begin
        errors++;
        if (mism++ < 10) $display("unexpected coverage word %0d", coverage_o);
      end else begin
        logic [COV_W-1:0] e;
        e = cov_q.pop_front();
        if (e !== coverage_o) begin
          errors++;
          if (mism++ < 10) $display("coverage mismatch: exp %0d got %0d", e, coverage_o);
        end
      end
    end
  end

  // watchdog on accepted words
  always @(posedge clk_i) begin
    if ((pixel_valid_i && pixel_ready_o) || (coverage_valid_o && coverage_ready_i) || psel)
      idle_cycles <= 0;
    else if (cov_q.size() != 0 || pixel_valid_i) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_MAX) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    row_t rows[$];
    int l, t, w, h, r, sw, md, x, y;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // after reset: empty rectangle
    send_pixel(0, 0, 0);
    send_pixel(-2048, 2047, 0);
    drain();

    set_shape(10, 20, 30, 16, 0, 1, MODE_FILL);
    rows = '{'{10, 20, 15}, '{39, 35, 15}, '{9, 20, 0}, '{40, 20, 0},
             '{2047, 2047, 0}, '{-2048, -2048, 0}};
    foreach (rows[i]) send_pixel(rows[i].x, rows[i].y, rows[i].c);
    drain();

    // rounded corners, fill / inner / outer, square rings, zero stroke, mode 3
    set_shape(-2048, -2048, 2047, 2047, 1023, 255, MODE_FILL);
    rows = '{'{-2048, -2048, -1}, '{-1025, -1025, 15}, '{-2048, -1025, -1},
             '{-2, -2, -1}};
    foreach (rows[i]) send_pixel(rows[i].x, rows[i].y, rows[i].c);
    drain();
    set_shape(0, 0, 40, 30, 8, 3, MODE_INNER);
    rows = '{'{0, 0, -1}, '{20, 0, 15}, '{20, 3, 0}, '{1, 1, -1}, '{39, 29, -1}};
    foreach (rows[i]) send_pixel(rows[i].x, rows[i].y, rows[i].c);
    drain();
    reg_write(REG_MODE, MODE_OUTER);
    rows = '{'{20, -1, 15}, '{20, -4, 0}, '{-2, -2, -1}, '{0, 0, -1}};
    foreach (rows[i]) send_pixel(rows[i].x, rows[i].y, rows[i].c);
    drain();
    reg_write(REG_RADIUS, 0);
    send_pixel(-3, -3, 15);
    send_pixel(-4, 5, 0);
    drain();
    reg_write(REG_MODE, MODE_INNER);
    send_pixel(2, 5, 15);
    send_pixel(3, 5, 0);
    drain();
    reg_write(REG_STROKE, 0);
    send_pixel(0, 0, 0);
    drain();
    reg_write(REG_STROKE, 2);
    reg_write(REG_MODE, 3);
    send_pixel(0, 0, 0);
    drain();

    // random phases: pixels mostly near the shape
    for (int ph = 0; ph < 30; ph++) begin
      w  = (ph % 7 == 0) ? $urandom_range(2047) : $urandom_range(64);
      h  = (ph % 5 == 0) ? $urandom_range(2047) : $urandom_range(64);
      l  = $urandom_range(4095) - 2048;
      t  = $urandom_range(4095) - 2048;
      r  = (ph % 4 == 0) ? $urandom_range(1023) : $urandom_range(20);
      sw = (ph % 6 == 0) ? $urandom_range(255) : $urandom_range(12);
      md = (ph % 11 == 10) ? 3 : ph % 3;
      set_shape(l, t, w, h, r, sw, md);
      quiet = (ph == 12);
      for (int k = 0; k < N_RAND / 30; k++) begin
        if ($urandom_range(9) == 0) begin
          x = $urandom_range(4095) - 2048;
          y = $urandom_range(4095) - 2048;
        end else begin
          x = l - sw - 2 + $urandom_range(w + 2 * sw + 4);
          y = t - sw - 2 + $urandom_range(h + 2 * sw + 4);
        end
        if (ph == 20 && k == 5) hold_rx = 1;
        send_pixel(x, y, -1);
      end
      drain();
    end
    quiet = 0;

    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  // long output stall while input keeps coming
  initial begin
    wait (hold_rx);
    repeat (300) @(negedge clk_i);
    hold_rx = 0;
  end
endmodule

/* rounded_rect_aa_coverage.f */
src/rrc_pkg.sv
src/rrc_front.sv
src/rrc_fifo.sv
src/rrc_back.sv
src/rounded_rect_aa_coverage.sv
src/rrc_checker.sv
verif/testbench.sv
